// ===== design/natural_log_atanh_series_assert.svh =====
// Assertion macros for the natural log block.
`ifndef NATURAL_LOG_ATANH_SERIES_ASSERT_SVH
`define NATURAL_LOG_ATANH_SERIES_ASSERT_SVH
// Implication checked every clock outside reset.
`define NLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Non-overlapping implication, checked in the next cycle.
`define NLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/nla_pkg.sv =====
// Package with types and constants of the natural log block.
package nla_pkg;
    localparam int XW  = 63;
    localparam int RW  = 64;
    localparam int CW  = 17;
    localparam logic [CW-1:0] TERM_RESET = 17'd1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDIV,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [0:0] {
        M_SQUARE,
        M_POWER
    } t_mul_op;
endpackage

// ===== design/natural_log_atanh_series.sv =====
// Top level: ln(x) by the atanh series on bit-serial divide and multiply units.
//
// Usage:
//  - Input channel i_x_value_valid/o_x_value_ready carries one item x.
//  - Output channel o_ln_value_valid/i_ln_value_ready returns ln(x), Q6.58.
//  - Config channel i_cfg_valid/o_cfg_ready writes term_count (17 bits);
//    write only while idle. Zero acts as one; values above MAX_TERMS clamp.
//  - One item at a time. Steps: r = (x-1)/(x+1) by restoring division, r*r
//    by shift-add multiply, then for each odd term k a restoring divide p/k
//    and a shift-add multiply p*r2, until n terms are summed or a zero power
//    ends the series early. Inputs of 0 or 1 skip the series and give a
//    zero result through S_DONE.
//  - The bit-serial divider (one quotient bit a cycle) and the shift-add
//    multiplier (one multiplier bit a cycle) set the rate; a new item is
//    taken only after the result is taken and the state returns to S_IDLE.
//  - Reset clears control and sets term_count to 1024; nothing is pending.
//  - A finished result sits in the output register until taken; the block
//    accepts no new item until then, so a stalled receiver holds the block.
`include "natural_log_atanh_series_assert.svh"
module natural_log_atanh_series
    import nla_pkg::*;
#(
    parameter int MAX_TERMS = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_x_value_valid,
    output logic            o_x_value_ready,
    input  logic [XW-1:0]   i_x_value,
    output logic            o_ln_value_valid,
    input  logic            i_ln_value_ready,
    output logic [RW-1:0]   o_ln_value,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CW-1:0]   i_cfg_term_count
);
    localparam int NW = $clog2(MAX_TERMS + 1);
    localparam logic [NW-1:0] MAXN = NW'(MAX_TERMS);

    t_state r_state, n_state;
    logic [CW-1:0]  r_term;
    logic [NW-1:0]  r_n, r_i;
    logic [RW-1:0]  r_r2, r_p, r_q;
    logic [RW:0]    r_rem, r_den;     // divider remainder and divisor
    logic [RW-1:0]  r_acc;            // low accumulator, divider quotient
    logic [5:0]     r_hi;
    logic [127:0]   r_prod;           // multiply accumulator / shifted multiplier
    logic [RW-1:0]  r_mcand;
    logic [6:0]     r_cnt;
    t_mul_op        r_mop;
    logic [RW-1:0]  r_out;
    logic           r_ovalid;

    logic           x_fire, last_bit, div_fit;
    logic [RW:0]    rem_sh, rem_sub;
    logic [RW:0]    madd;
    logic [RW:0]    lo_sum;
    logic [RW-1:0]  x_ext;

    assign o_x_value_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready      = (r_state == S_IDLE);
    assign x_fire           = i_x_value_valid && o_x_value_ready;
    assign o_ln_value_valid = r_ovalid;
    assign o_ln_value       = r_out;
    assign last_bit         = (r_cnt == 7'd63);
    assign x_ext            = {1'b0, i_x_value};

    // One restoring division step: shift in a zero, subtract when it fits.
    assign rem_sh  = {r_rem[RW-1:0], 1'b0};
    assign rem_sub = rem_sh - r_den;
    // One shift-add multiply step on the low multiplier bit.
    assign madd    = {1'b0, r_prod[127:64]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
    // Term divide: quotient bit of this step, and the accumulator plus the term.
    assign div_fit = ({rem_sh[RW:1], r_mcand[RW-1]} >= r_den);
    assign lo_sum  = {1'b0, r_acc} + {1'b0, r_q[RW-2:0], div_fit};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (x_fire) n_state = (i_x_value <= XW'(1)) ? S_DONE : S_RDIV;
            S_RDIV: if (last_bit) n_state = S_MUL;
            S_MUL:  if (last_bit) begin
                if (r_mop == M_SQUARE) n_state = S_DIV;
                else if (r_i == r_n || madd[RW:1] == '0)
                    n_state = S_DONE;
                else n_state = S_DIV;
            end
            S_DIV:  if (last_bit) n_state = S_MUL;
            S_DONE: if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_term   <= TERM_RESET;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_hi     <= '0;
            r_i      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_term <= i_cfg_term_count;
            if (r_ovalid && i_ln_value_ready) r_ovalid <= 1'b0;
            r_cnt <= (r_state == S_RDIV || r_state == S_MUL || r_state == S_DIV)
                     ? (last_bit ? 7'd0 : r_cnt + 7'd1) : 7'd0;
            unique case (r_state)
                S_IDLE: if (x_fire) begin
                    // clamp the term count
                    if (r_term == '0) r_n <= NW'(1);
                    else if ({{(32-CW){1'b0}}, r_term} > 32'(MAX_TERMS)) r_n <= MAXN;
                    else r_n <= NW'(r_term);
                    r_rem   <= {2'b0, x_ext[RW-2:0]} - (RW+1)'(1);
                    r_den   <= {2'b0, x_ext[RW-2:0]} + (RW+1)'(1);
                    r_acc   <= '0;
                    r_hi    <= '0;
                    r_i     <= '0;
                    r_out   <= '0;
                end
                S_RDIV: begin
                    if (rem_sh >= r_den) r_rem <= rem_sub;
                    else r_rem <= rem_sh;
                    r_acc <= {r_acc[RW-2:0], rem_sh >= r_den};
                    if (last_bit) begin
                        // r is the quotient; start r*r and clear the sum
                        r_p     <= {r_acc[RW-2:0], rem_sh >= r_den};
                        r_mcand <= {r_acc[RW-2:0], rem_sh >= r_den};
                        r_prod  <= {64'd0, r_acc[RW-2:0], rem_sh >= r_den};
                        r_mop   <= M_SQUARE;
                        r_acc   <= '0;
                    end
                end
                S_MUL: begin
                    r_prod <= {madd, r_prod[63:1]};
                    if (last_bit) begin
                        if (r_mop == M_SQUARE) begin
                            r_r2 <= madd[RW:1];
                        end else begin
                            r_p <= madd[RW:1];
                        end
                        // start p/k for the next term; k = 2i+1
                        r_rem <= '0;
                        r_den <= (RW+1)'({r_i, 1'b1});
                        r_q   <= '0;
                        if (r_mop == M_SQUARE) r_mcand <= r_p;
                        else r_mcand <= madd[RW:1];
                        if (n_state == S_DONE) begin
                            r_out    <= (r_hi[5]) ? '1 : {r_hi[4:0], r_acc[RW-1:5]};
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    // dividend bits come from r_mcand, msb first
                    if (div_fit)
                        r_rem <= {rem_sh[RW:1], r_mcand[RW-1]} - r_den;
                    else
                        r_rem <= {rem_sh[RW:1], r_mcand[RW-1]};
                    r_mcand <= {r_mcand[RW-2:0], 1'b0};
                    r_q <= {r_q[RW-2:0], div_fit};
                    if (last_bit) begin
                        r_acc <= lo_sum[RW-1:0];
                        r_hi  <= r_hi + 6'(lo_sum[RW]);
                        r_i   <= r_i + NW'(1);
                        r_mcand <= r_r2;
                        r_prod  <= {64'd0, r_p};
                        r_mop   <= M_POWER;
                    end
                end
                S_DONE: if (r_cnt == '0 && !r_ovalid && r_i == '0 && r_acc == '0
                            && r_state != n_state) begin
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    `NLA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_x_value_ready)
    `NLA_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 7'd63)
    `NLA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !i_ln_value_ready,
        r_ovalid && $stable(r_out))
    `NLA_ASSERT_IMP(a_terms_bound, i_clk, i_rst_n, r_state == S_DIV, r_i < r_n)
endmodule
